### rtl/tqsa_pkg.sv
// Shared types, codes and defaults for the two-queue shared-store block.
package tqsa_pkg;

   // Defaults for the top-level parameters
   localparam int DEPTH_DEF      = 128;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 8;

   // Queue size after reset (clamped to the store depth where used)
   localparam int SIZE_RESET = 128;

   // Operation requested by one request
   typedef enum logic [MODE_W-1:0] {
      MODE_ENQ_LOW  = 2'd0,
      MODE_DEQ_LOW  = 2'd1,
      MODE_ENQ_HIGH = 2'd2,
      MODE_DEQ_HIGH = 2'd3
   } mode_type;

   // Result status
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Store access that the back end carries out
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   // Control part of one classified command
   typedef struct packed {
      kind_type   kind;
      status_type status;
   } cmd_ctl_type;

endpackage

### rtl/two_queues_shared_array_top.sv
// Top level of the two-queue shared-store block.
//
// Two FIFO queues share one store of DEPTH words: the lower queue grows up from entry 0, the
// upper queue grows down from entry queue_size-1, and both refuse enqueues once their tails
// meet. Space freed at a head comes back only when that queue drains. The block takes one
// request per cycle sustained while results are taken; a result passes through the two-entry
// command queue and then the response register, which holds the registered read of the store.
// A write to queue_size restarts all pointers and leaves the store contents alone; there is
// no clearing pass, so the block is ready right after reset.
module two_queues_shared_array_top #(
   parameter int DEPTH      = tqsa_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = tqsa_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tqsa_pkg::CFG_W-1:0]          csr_wdata,   // queue_size
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]     req_tdata,   // value
   input  logic [tqsa_pkg::MODE_W-1:0]         req_tuser,   // mode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((DATA_WIDTH+7)/8)*8-1:0]     rsp_tdata,   // data
   output logic [tqsa_pkg::STATUS_W-1:0]       rsp_tuser    // status
);
   import tqsa_pkg::*;

   localparam int AW      = $clog2(DEPTH);
   localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

   logic                  q_ready;
   logic                  q_push;
   cmd_ctl_type           push_ctl;
   logic [AW-1:0]         push_addr;
   logic [DATA_WIDTH-1:0] push_wdata;
   logic                  q_valid;
   logic                  q_pop;
   cmd_ctl_type           pop_ctl;
   logic [AW-1:0]         pop_addr;
   logic [DATA_WIDTH-1:0] pop_wdata;
   logic [DATA_WIDTH-1:0] rsp_data;

   tqsa_front #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .req_value  (req_tdata[DATA_WIDTH-1:0]),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_ctl      (push_ctl),
      .q_addr     (push_addr),
      .q_wdata    (push_wdata)
   );

   tqsa_queue #(
      .AW         (AW),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_ctl   (push_ctl),
      .push_addr  (push_addr),
      .push_wdata (push_wdata),
      .ready      (q_ready),
      .pop        (q_pop),
      .valid      (q_valid),
      .pop_ctl    (pop_ctl),
      .pop_addr   (pop_addr),
      .pop_wdata  (pop_wdata)
   );

   tqsa_back #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_ctl      (pop_ctl),
      .q_addr     (pop_addr),
      .q_wdata    (pop_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = TDATA_W'(rsp_data);

`ifndef ASSERT_OFF
   // A refused request carries zero data
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_OK)) |-> (rsp_tdata == '0))
      else $error("nonzero data on a refused result");

   // Status is always one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == ST_OK) || (rsp_tuser == ST_FULL) ||
                      (rsp_tuser == ST_EMPTY)))
      else $error("unused status code on result");

   // A request into an idle block yields its result through the command queue and the response register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !q_valid && !rsp_tvalid) |=> ##1 rsp_tvalid)
      else $error("result missing after idle request");

   // Reset empties the queue and the response register
   a_reset: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !q_valid && req_tready))
      else $error("pipeline not empty after reset");
`endif

endmodule

### rtl/tqsa_front.sv
// Front end: accepts requests, checks full and empty, updates the queue pointers and applies queue_size writes.
module tqsa_front #(
   parameter int DEPTH      = tqsa_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = tqsa_pkg::DATA_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [tqsa_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [tqsa_pkg::MODE_W-1:0]    req_mode,
   input  logic [DATA_WIDTH-1:0]          req_value,
   input  logic                           q_ready,
   output logic                           q_push,
   output tqsa_pkg::cmd_ctl_type          q_ctl,
   output logic [$clog2(DEPTH)-1:0]       q_addr,
   output logic [DATA_WIDTH-1:0]          q_wdata
);
   import tqsa_pkg::*;

   localparam int AW       = $clog2(DEPTH);
   localparam int CW       = $clog2(DEPTH + 1);
   localparam int SW       = (CW > CFG_W) ? CW : CFG_W;
   localparam int SIZE_RST = (SIZE_RESET > DEPTH) ? DEPTH : SIZE_RESET;

   // lt = low_tail + 1, lh = low_head, ht = high_tail, hh = high_head + 1
   logic [CW-1:0] size_ff, size_in;
   logic [CW-1:0] lt_ff, lt_in;
   logic [CW-1:0] lh_ff, lh_in;
   logic [CW-1:0] ht_ff, ht_in;
   logic [CW-1:0] hh_ff, hh_in;

   logic          accept;
   logic          full;
   logic          low_empty;
   logic          high_empty;
   logic [CW-1:0] lh_next;
   logic [CW-1:0] hh_next;
   logic [CW-1:0] ht_next;
   logic [SW-1:0] cfg_ext;
   mode_type      mode;

   assign req_tready = q_ready;
   assign accept     = req_tvalid && q_ready;
   assign q_push     = accept;
   assign q_wdata    = req_value;
   assign mode       = mode_type'(req_mode);

   assign full       = (ht_ff == lt_ff);
   assign low_empty  = (lh_ff >= lt_ff);
   assign high_empty = (hh_ff <= ht_ff);
   assign lh_next    = lh_ff + CW'(1);
   assign hh_next    = hh_ff - CW'(1);
   assign ht_next    = ht_ff - CW'(1);
   assign cfg_ext    = SW'(csr_wdata);

   // Classify the request and work out the pointer updates
   always_comb begin
      size_in      = size_ff;
      lt_in        = lt_ff;
      lh_in        = lh_ff;
      ht_in        = ht_ff;
      hh_in        = hh_ff;
      q_ctl.kind   = KIND_NONE;
      q_ctl.status = ST_OK;
      q_addr       = '0;
      if (csr_we) begin
         // Clamp the size and restart all pointers
         if (cfg_ext == '0) begin
            size_in = CW'(1);
         end else if (cfg_ext > SW'(DEPTH)) begin
            size_in = CW'(DEPTH);
         end else begin
            size_in = CW'(cfg_ext);
         end
         lt_in = '0;
         lh_in = '0;
         ht_in = size_in;
         hh_in = size_in;
      end else if (accept) begin
         unique case (mode)
            MODE_ENQ_LOW: begin
               if (full) begin
                  q_ctl.status = ST_FULL;
               end else begin
                  q_ctl.kind = KIND_WRITE;
                  q_addr     = lt_ff[AW-1:0];
                  lt_in      = lt_ff + CW'(1);
               end
            end
            MODE_DEQ_LOW: begin
               if (low_empty) begin
                  q_ctl.status = ST_EMPTY;
               end else begin
                  q_ctl.kind = KIND_READ;
                  q_addr     = lh_ff[AW-1:0];
                  // Drained: return to the start of the store
                  if (lh_next >= lt_ff) begin
                     lh_in = '0;
                     lt_in = '0;
                  end else begin
                     lh_in = lh_next;
                  end
               end
            end
            MODE_ENQ_HIGH: begin
               if (full) begin
                  q_ctl.status = ST_FULL;
               end else begin
                  q_ctl.kind = KIND_WRITE;
                  q_addr     = ht_next[AW-1:0];
                  ht_in      = ht_next;
               end
            end
            MODE_DEQ_HIGH: begin
               if (high_empty) begin
                  q_ctl.status = ST_EMPTY;
               end else begin
                  q_ctl.kind = KIND_READ;
                  q_addr     = hh_next[AW-1:0];
                  // Drained: return to the top of the used store
                  if (hh_next <= ht_ff) begin
                     hh_in = size_ff;
                     ht_in = size_ff;
                  end else begin
                     hh_in = hh_next;
                  end
               end
            end
            default: begin
               q_ctl.kind = KIND_NONE;
            end
         endcase
      end
   end

   // Hold size and pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= CW'(SIZE_RST);
         lt_ff   <= '0;
         lh_ff   <= '0;
         ht_ff   <= CW'(SIZE_RST);
         hh_ff   <= CW'(SIZE_RST);
      end else begin
         size_ff <= size_in;
         lt_ff   <= lt_in;
         lh_ff   <= lh_in;
         ht_ff   <= ht_in;
         hh_ff   <= hh_in;
      end
   end

endmodule

### rtl/tqsa_queue.sv
// Two-entry command queue between the front end and the back end.
module tqsa_queue #(
   parameter int AW         = $clog2(tqsa_pkg::DEPTH_DEF),
   parameter int DATA_WIDTH = tqsa_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tqsa_pkg::cmd_ctl_type push_ctl,
   input  logic [AW-1:0]         push_addr,
   input  logic [DATA_WIDTH-1:0] push_wdata,
   output logic                  ready,
   input  logic                  pop,
   output logic                  valid,
   output tqsa_pkg::cmd_ctl_type pop_ctl,
   output logic [AW-1:0]         pop_addr,
   output logic [DATA_WIDTH-1:0] pop_wdata
);
   import tqsa_pkg::*;

   cmd_ctl_type           ctl_ff   [2];
   logic [AW-1:0]         addr_ff  [2];
   logic [DATA_WIDTH-1:0] wdata_ff [2];

   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign ready     = (count_ff != 2'd2);
   assign valid     = (count_ff != 2'd0);
   assign pop_ctl   = ctl_ff[rd_ptr_ff];
   assign pop_addr  = addr_ff[rd_ptr_ff];
   assign pop_wdata = wdata_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[wr_ptr_ff]   <= push_ctl;
         addr_ff[wr_ptr_ff]  <= push_addr;
         wdata_ff[wr_ptr_ff] <= push_wdata;
      end
   end

endmodule

### rtl/tqsa_back.sv
// Back end: carries out store writes and reads and holds the response register.
module tqsa_back #(
   parameter int DEPTH      = tqsa_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = tqsa_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_pop,
   input  tqsa_pkg::cmd_ctl_type         q_ctl,
   input  logic [$clog2(DEPTH)-1:0]      q_addr,
   input  logic [DATA_WIDTH-1:0]         q_wdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tqsa_pkg::STATUS_W-1:0] rsp_status,
   output logic [DATA_WIDTH-1:0]         rsp_data
);
   import tqsa_pkg::*;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic                  valid_ff, valid_in;
   status_type            status_ff;
   logic                  is_read_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Take the next command once the response register is free
   assign q_pop      = q_valid && (!valid_ff || rsp_tready);
   assign valid_in   = q_pop || (valid_ff && !rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_data   = is_read_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load response fields on pop
   always_ff @(posedge clock) begin
      if (q_pop) begin
         status_ff  <= q_ctl.status;
         is_read_ff <= (q_ctl.kind == KIND_READ);
      end
   end

   // Store access with registered read data
   always_ff @(posedge clock) begin
      if (q_pop && (q_ctl.kind == KIND_WRITE)) begin
         mem[q_addr] <= q_wdata;
      end
      if (q_pop && (q_ctl.kind == KIND_READ)) begin
         rd_data_ff <= mem[q_addr];
      end
   end

endmodule

### bench/two_queues_shared_array_top_test.sv
// Self-checking testbench for the two-queue shared-store block.
module two_queues_shared_array_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tqsa_pkg::*;

   localparam int STORE_DEPTH = DEPTH_DEF;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] value;
   } queue_request_type;

   typedef struct packed {
      logic [31:0] data;
      status_type  status;
   } queue_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;        // value
   logic [MODE_W-1:0] req_tuser = '0;  // mode
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;             // data
   logic [STATUS_W-1:0] rsp_tuser;     // status

   // Shadow of the block's state
   logic [31:0] shadow_store [0:STORE_DEPTH-1];
   int queue_size;
   int lo_head, lo_tail, hi_head, hi_tail;

   queue_request_type requests_to_send[$];
   queue_result_type awaited_results[$];
   queue_request_type presented;
   logic calm = 1'b0;
   int mismatches = 0;
   int cycles = 0;

   two_queues_shared_array_top uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // Return both queues to their start positions
   function automatic void restart_pointers();
      lo_head = 0;
      lo_tail = -1;
      hi_head = queue_size - 1;
      hi_tail = queue_size;
   endfunction

   // Apply one request to the shadow state and queue up the result it should give
   function automatic void apply_queue_op(mode_type op, logic [31:0] value);
      queue_result_type r;
      logic full;
      r.data = '0;
      r.status = ST_OK;
      full = (hi_tail - lo_tail) == 1;
      case (op)
         MODE_ENQ_LOW: begin
            if (full) begin
               r.status = ST_FULL;
            end else begin
               lo_tail++;
               shadow_store[lo_tail] = value;
            end
         end
         MODE_DEQ_LOW: begin
            if (lo_head > lo_tail) begin
               r.status = ST_EMPTY;
            end else begin
               r.data = shadow_store[lo_head];
               lo_head++;
               // drained: space comes back only now
               if (lo_head > lo_tail) begin
                  lo_head = 0;
                  lo_tail = -1;
               end
            end
         end
         MODE_ENQ_HIGH: begin
            if (full) begin
               r.status = ST_FULL;
            end else begin
               hi_tail--;
               shadow_store[hi_tail] = value;
            end
         end
         default: begin
            if (hi_head < hi_tail) begin
               r.status = ST_EMPTY;
            end else begin
               r.data = shadow_store[hi_head];
               hi_head--;
               if (hi_head < hi_tail) begin
                  hi_head = queue_size - 1;
                  hi_tail = queue_size;
               end
            end
         end
      endcase
      awaited_results.push_back(r);
   endfunction

   // Write queue_size while idle and mirror the clamp and pointer restart
   task automatic set_queue_size(logic [CFG_W-1:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (v == 0) begin
         queue_size = 1;
      end else if (v > STORE_DEPTH) begin
         queue_size = STORE_DEPTH;
      end else begin
         queue_size = int'(v);
      end
      restart_pointers();
   endtask

   function automatic void push_item(mode_type op, logic [31:0] value);
      queue_request_type q;
      q.mode = op;
      q.value = value;
      requests_to_send.push_back(q);
   endfunction

   // Random requests; enq_pct steers toward filling or draining
   function automatic void add_random_items(int n, int enq_pct);
      logic enq;
      logic upper;
      logic [31:0] v;
      for (int i = 0; i < n; i++) begin
         enq = $urandom_range(0, 99) < enq_pct;
         upper = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 15))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 32'hFFFF_FFFF;
            3: v = 32'h0000_0000;
            default: v = $urandom;
         endcase
         if (upper) begin
            if (enq) begin
               push_item(MODE_ENQ_HIGH, v);
            end else begin
               push_item(MODE_DEQ_HIGH, v);
            end
         end else begin
            if (enq) begin
               push_item(MODE_ENQ_LOW, v);
            end else begin
               push_item(MODE_DEQ_LOW, v);
            end
         end
      end
   endfunction

   // Wait until every request is taken and every result is back
   task automatic finish_phase();
      do @(negedge clock); while (requests_to_send.size() != 0 || req_tvalid);
      do @(negedge clock); while (awaited_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Request driver: hold valid until taken, then advance or idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_queue_op(presented.mode, presented.value);
         end
         if (!req_tvalid || req_tready) begin
            if (requests_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
               presented = requests_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= presented.mode;
               req_tdata <= presented.value;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: stall at random, check each result against the oldest expectation
   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 25);
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result: data %h status %0d", rsp_tdata, rsp_tuser);
               end
            end else begin
               want = awaited_results.pop_front();
               if (rsp_tdata !== want.data || rsp_tuser !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected data %h status %0d, got data %h status %0d",
                              want.data, want.status, rsp_tdata, rsp_tuser);
                  end
               end
            end
         end
      end
   end

   // Guard against a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("two_queues_shared_array_top regression: fail");
         $finish;
      end
   end

   initial begin
      logic [CFG_W-1:0] sz;
      queue_size = SIZE_RESET;
      restart_pointers();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset size: empty refusals, extreme values, FIFO order, drain and restart
      push_item(MODE_DEQ_LOW, 32'h1234_5678);
      push_item(MODE_DEQ_HIGH, 32'h0);
      push_item(MODE_ENQ_LOW, 32'h7FFF_FFFF);
      push_item(MODE_ENQ_LOW, 32'h8000_0000);
      push_item(MODE_ENQ_HIGH, 32'hFFFF_FFFF);
      push_item(MODE_ENQ_HIGH, 32'h0000_0000);
      push_item(MODE_DEQ_LOW, 32'h0);
      push_item(MODE_DEQ_LOW, 32'h0);
      push_item(MODE_DEQ_HIGH, 32'h0);
      push_item(MODE_DEQ_HIGH, 32'h0);
      finish_phase();

      // Size written as zero is taken as one: a single entry fills the shared space
      set_queue_size(8'd0);
      push_item(MODE_ENQ_LOW, 32'hA5A5_A5A5);
      push_item(MODE_ENQ_HIGH, 32'h5A5A_5A5A);
      push_item(MODE_ENQ_LOW, 32'h1);
      push_item(MODE_DEQ_HIGH, 32'h0);
      push_item(MODE_DEQ_LOW, 32'h0);
      push_item(MODE_ENQ_HIGH, 32'hDEAD_BEEF);
      push_item(MODE_ENQ_LOW, 32'h2);
      push_item(MODE_DEQ_HIGH, 32'h0);
      finish_phase();

      // Freed head space stays unused until the queue drains
      set_queue_size(8'd3);
      push_item(MODE_ENQ_LOW, 32'h0000_0011);
      push_item(MODE_ENQ_LOW, 32'h0000_0022);
      push_item(MODE_DEQ_LOW, 32'h0);
      push_item(MODE_ENQ_HIGH, 32'h0000_0033);
      push_item(MODE_ENQ_LOW, 32'h0000_0044);
      push_item(MODE_DEQ_LOW, 32'h0);
      push_item(MODE_ENQ_LOW, 32'h0000_0055);
      finish_phase();

      // Size above the store is clamped; push it toward full with no idling
      set_queue_size(8'd255);
      calm <= 1'b1;
      add_random_items(180, 85);
      finish_phase();
      calm <= 1'b0;

      // Mostly small sizes so that full and drain happen often
      for (int p = 0; p < 10; p++) begin
         if (p == 0) begin
            sz = 8'd128;
         end else if (p % 4 == 3) begin
            sz = CFG_W'($urandom_range(0, 255));
         end else begin
            sz = CFG_W'($urandom_range(1, 12));
         end
         set_queue_size(sz);
         add_random_items(30, (p % 2) ? 30 : 75);
         finish_phase();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("two_queues_shared_array_top regression: pass");
      end else begin
         $display("two_queues_shared_array_top regression: fail");
      end
      $finish;
   end

endmodule
